// ===== rtl/core/macd_pkg.sv =====
package macd_pkg;

   typedef struct packed {
      logic [47:0] close_price;
      logic        series_start;
   } req_type;

   typedef struct packed {
      logic signed [63:0] macd_value;
      logic               macd_valid;
      logic signed [63:0] signal_value;
      logic               signal_valid;
      logic signed [63:0] histogram;
   } rsp_type;

   // register indexes
   localparam logic [2:0] CSR_FAST_GAIN     = 3'd0;
   localparam logic [2:0] CSR_SLOW_GAIN     = 3'd1;
   localparam logic [2:0] CSR_SIGNAL_GAIN   = 3'd2;
   localparam logic [2:0] CSR_MACD_WARMUP   = 3'd3;
   localparam logic [2:0] CSR_SIGNAL_WARMUP = 3'd4;

   // operand selects
   localparam logic [1:0] SEL_FAST   = 2'd0;
   localparam logic [1:0] SEL_SLOW   = 2'd1;
   localparam logic [1:0] SEL_SIGNAL = 2'd2;

   // jump conditions
   localparam logic [2:0] JC_NONE         = 3'd0;
   localparam logic [2:0] JC_NO_REQ       = 3'd1;
   localparam logic [2:0] JC_START        = 3'd2;
   localparam logic [2:0] JC_MACD_INVALID = 3'd3;
   localparam logic [2:0] JC_RSP_BUSY     = 3'd4;

   // program steps
   localparam logic [3:0] STEP_IDLE     = 4'd0;
   localparam logic [3:0] STEP_FIRST    = 4'd1;
   localparam logic [3:0] STEP_MUL_FAST = 4'd2;
   localparam logic [3:0] STEP_MUL_SLOW = 4'd3;
   localparam logic [3:0] STEP_ACC_SLOW = 4'd4;
   localparam logic [3:0] STEP_MACD     = 4'd5;
   localparam logic [3:0] STEP_SIG_DIFF = 4'd6;
   localparam logic [3:0] STEP_SIG_MUL  = 4'd7;
   localparam logic [3:0] STEP_SIG_UPD  = 4'd8;
   localparam logic [3:0] STEP_OUT      = 4'd9;

   typedef struct packed {
      logic       accept_en;
      logic       first;
      logic       diff_load;
      logic [1:0] diff_sel;
      logic       mul_en;
      logic [1:0] gain_sel;
      logic       acc_fast;
      logic       acc_slow;
      logic       macd_load;
      logic       sig_upd;
      logic       rsp_load;
      logic       last;
      logic [2:0] jump_cond;
      logic [3:0] target;
   } ctl_type;

   typedef struct packed {
      logic req_valid;
      logic start;
      logic macd_invalid;
      logic rsp_busy;
   } cond_type;

   function automatic ctl_type program_rom(input logic [3:0] step);
      ctl_type c;
      c = '0;
      c.diff_sel = SEL_FAST;
      c.gain_sel = SEL_FAST;
      c.jump_cond = JC_NONE;
      c.target = STEP_IDLE;
      case (step)
         STEP_IDLE: begin
            c.accept_en = 1'b1;
            c.jump_cond = JC_NO_REQ;
            c.target    = STEP_IDLE;
         end
         STEP_FIRST: begin
            c.first     = 1'b1;
            c.diff_load = 1'b1;
            c.diff_sel  = SEL_FAST;
            c.jump_cond = JC_START;
            c.target    = STEP_MACD;
         end
         STEP_MUL_FAST: begin
            c.mul_en    = 1'b1;
            c.gain_sel  = SEL_FAST;
            c.diff_load = 1'b1;
            c.diff_sel  = SEL_SLOW;
         end
         STEP_MUL_SLOW: begin
            c.acc_fast = 1'b1;
            c.mul_en   = 1'b1;
            c.gain_sel = SEL_SLOW;
         end
         STEP_ACC_SLOW: begin
            c.acc_slow = 1'b1;
         end
         STEP_MACD: begin
            c.macd_load = 1'b1;
         end
         STEP_SIG_DIFF: begin
            c.diff_load = 1'b1;
            c.diff_sel  = SEL_SIGNAL;
            c.jump_cond = JC_MACD_INVALID;
            c.target    = STEP_OUT;
         end
         STEP_SIG_MUL: begin
            c.mul_en   = 1'b1;
            c.gain_sel = SEL_SIGNAL;
         end
         STEP_SIG_UPD: begin
            c.sig_upd = 1'b1;
         end
         STEP_OUT: begin
            c.rsp_load  = 1'b1;
            c.last      = 1'b1;
            c.jump_cond = JC_RSP_BUSY;
            c.target    = STEP_OUT;
         end
         default: begin
            c.last = 1'b1;
         end
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/core/macd_signal_line_top.sv =====
// MACD with signal line over a stream of bar closes. Each item carries one close (Q.16) and a
// series start flag and yields exactly one result item: MACD, signal line and histogram with
// FRACTION_BITS fraction bits, MACD and signal line each with its valid flag. A small
// microprogram steps a single shared 64x16 multiplier through the fast, slow and signal averages.
// One item runs from acceptance in IDLE through FIRST, MUL_FAST, MUL_SLOW, ACC_SLOW, MACD, SIG_DIFF,
// SIG_MUL, SIG_UPD and OUT back to IDLE; SIG_MUL and SIG_UPD are skipped while MACD is not yet
// valid, and a series start bar goes from FIRST straight to MACD. OUT holds while the result
// register is stalled. The result register lets the next item be accepted while the previous result still waits.
module macd_signal_line_top import macd_pkg::*; #(
   parameter int FRACTION_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int CLOSE_SHIFT = FRACTION_BITS - 16;

   ctl_type    ctl;
   cond_type   cond;
   logic [3:0] step;

   logic [15:0] fast_gain_ff, slow_gain_ff, signal_gain_ff;
   logic [7:0]  macd_warmup_ff, signal_warmup_ff;

   logic [63:0] close_ff;
   logic        start_ff;
   logic [63:0] fast_ff, slow_ff, sig_ff;
   logic [7:0]  bar_ff, count_ff;
   logic [63:0] diff_ff, prod_ff, macd_ff;
   logic        mvalid_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   logic               req_accept;
   logic               rsp_busy;
   logic [63:0]        diff_x, diff_avg;
   logic [15:0]        gain_mux;
   logic signed [80:0] prod_full;
   logic               svalid;

   assign req_ready  = ctl.accept_en;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_busy   = rsp_valid_ff && !rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign cond.req_valid    = req_valid;
   assign cond.start        = start_ff;
   assign cond.macd_invalid = !mvalid_ff;
   assign cond.rsp_busy     = rsp_busy;

   macd_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctl   (ctl),
      .step  (step)
   );

   always_comb begin
      diff_x = (ctl.diff_sel == SEL_SIGNAL) ? macd_ff : close_ff;
      case (ctl.diff_sel)
         SEL_FAST:   diff_avg = fast_ff;
         SEL_SLOW:   diff_avg = slow_ff;
         SEL_SIGNAL: diff_avg = sig_ff;
         default:    diff_avg = fast_ff;
      endcase
      case (ctl.gain_sel)
         SEL_FAST:   gain_mux = fast_gain_ff;
         SEL_SLOW:   gain_mux = slow_gain_ff;
         SEL_SIGNAL: gain_mux = signal_gain_ff;
         default:    gain_mux = fast_gain_ff;
      endcase
   end

   assign prod_full = $signed(diff_ff) * $signed({1'b0, gain_mux});
   assign svalid    = mvalid_ff && (count_ff >= signal_warmup_ff);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_gain_ff     <= 16'd10082;
         slow_gain_ff     <= 16'd4855;
         signal_gain_ff   <= 16'd13107;
         macd_warmup_ff   <= 8'd25;
         signal_warmup_ff <= 8'd9;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FAST_GAIN:     fast_gain_ff     <= csr_data;
            CSR_SLOW_GAIN:     slow_gain_ff     <= csr_data;
            CSR_SIGNAL_GAIN:   signal_gain_ff   <= csr_data;
            CSR_MACD_WARMUP:   macd_warmup_ff   <= csr_data[7:0];
            CSR_SIGNAL_WARMUP: signal_warmup_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         close_ff <= {16'd0, req_data.close_price} << CLOSE_SHIFT;
         start_ff <= req_data.series_start;
      end
      if (ctl.diff_load) begin
         diff_ff <= diff_x - diff_avg;
      end
      if (ctl.mul_en) begin
         prod_ff <= prod_full[79:16];
      end
      if (ctl.macd_load) begin
         macd_ff <= fast_ff - slow_ff;
      end
   end

   // series state
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_ff   <= '0;
         slow_ff   <= '0;
         sig_ff    <= '0;
         bar_ff    <= '0;
         count_ff  <= '0;
         mvalid_ff <= 1'b0;
      end else begin
         if (ctl.first) begin
            if (start_ff) begin
               bar_ff   <= '0;
               fast_ff  <= close_ff;
               slow_ff  <= close_ff;
               sig_ff   <= '0;
               count_ff <= '0;
            end else if (bar_ff != 8'hFF) begin
               bar_ff <= bar_ff + 8'd1;
            end
         end
         if (ctl.acc_fast) begin
            fast_ff <= fast_ff + prod_ff;
         end
         if (ctl.acc_slow) begin
            slow_ff <= slow_ff + prod_ff;
         end
         if (ctl.macd_load) begin
            mvalid_ff <= (bar_ff >= macd_warmup_ff);
         end
         if (ctl.sig_upd) begin
            if (count_ff == 8'd0) begin
               sig_ff <= macd_ff;
            end else begin
               sig_ff <= sig_ff + prod_ff;
            end
            if (count_ff != 8'hFF) begin
               count_ff <= count_ff + 8'd1;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.rsp_load && !rsp_busy) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load && !rsp_busy) begin
         rsp_ff.macd_value   <= mvalid_ff ? $signed(macd_ff) : 64'sd0;
         rsp_ff.macd_valid   <= mvalid_ff;
         rsp_ff.signal_value <= svalid ? $signed(sig_ff) : 64'sd0;
         rsp_ff.signal_valid <= svalid;
         rsp_ff.histogram    <= svalid ? $signed(macd_ff - sig_ff) : 64'sd0;
      end
   end

   a_accept_starts_program: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> step == STEP_FIRST)
      else $error("program did not start after an accepted item");

   a_bar_saturates: assert property (@(posedge clock) disable iff (reset)
      (bar_ff == 8'hFF && !(ctl.first && start_ff)) |=> bar_ff == 8'hFF)
      else $error("bar index left saturation");

   a_signal_needs_macd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ff.signal_valid || rsp_ff.macd_valid))
      else $error("signal valid without valid macd");

   a_sig_update_valid: assert property (@(posedge clock) disable iff (reset)
      ctl.sig_upd |-> mvalid_ff)
      else $error("signal line updated from an invalid macd");

endmodule

// ===== rtl/core/macd_seq.sv =====
module macd_seq import macd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cond_type cond,
   output ctl_type  ctl,
   output logic [3:0] step
);

   logic [3:0] step_ff;
   logic [3:0] step_in;
   logic       taken;

   assign ctl  = program_rom(step_ff);
   assign step = step_ff;

   always_comb begin
      case (ctl.jump_cond)
         JC_NONE:         taken = 1'b0;
         JC_NO_REQ:       taken = !cond.req_valid;
         JC_START:        taken = cond.start;
         JC_MACD_INVALID: taken = cond.macd_invalid;
         JC_RSP_BUSY:     taken = cond.rsp_busy;
         default:         taken = 1'b0;
      endcase
      if (taken) begin
         step_in = ctl.target;
      end else if (ctl.last) begin
         step_in = STEP_IDLE;
      end else begin
         step_in = step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
